>>> rtl/abdc_pkg.sv
// ----------------------------------------------------------------------------
// abdc_pkg
// Shared constants, types and register codes of the anchor box decoder.
// ----------------------------------------------------------------------------
package abdc_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int DELTA_FRAC_BITS = 12;

  localparam int ANCHOR_W = 20;
  localparam int CELL_W   = 10;
  localparam int DELTA_W  = 16;
  localparam int BOX_W    = 17;
  localparam int SCORE_W  = 16;

  localparam int SIZE_W   = 14;
  localparam int STRIDE_W = 9;
  localparam int SIZE_MAX = 8192;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 14;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH    = 4'd0,
    REG_IMAGE_HEIGHT   = 4'd1,
    REG_CELL_STRIDE    = 4'd2,
    REG_TRANSFORM_MODE = 4'd3
  } reg_index_t;

  localparam int RST_IMAGE_WIDTH  = 1024;
  localparam int RST_IMAGE_HEIGHT = 1024;
  localparam int RST_CELL_STRIDE  = 16;
  localparam int RST_MODE         = 1;

  // exp unit: input is a 17-bit signed value with DELTA_FRAC_BITS fraction
  localparam int EXP_IN_W   = DELTA_W + 1;
  localparam int EXP_W      = 32;
  localparam int LOG2E_Q16  = 94548;
  localparam int POLY_C1    = 45578;
  localparam int POLY_C2    = 14813;
  localparam int POLY_C3    = 5145;

  // quotient of the objectness divide is below 2^17
  localparam int QUOT_W     = 17;

  // register levels from input transfer to the final result register
  localparam int PIPE_LEVELS = 13;

  typedef struct packed {
    logic signed [ANCHOR_W-1:0] anchor_left;
    logic signed [ANCHOR_W-1:0] anchor_top;
    logic signed [ANCHOR_W-1:0] anchor_right;
    logic signed [ANCHOR_W-1:0] anchor_bottom;
    logic        [CELL_W-1:0]   cell_col;
    logic        [CELL_W-1:0]   cell_row;
    logic signed [DELTA_W-1:0]  delta_a;
    logic signed [DELTA_W-1:0]  delta_b;
    logic signed [DELTA_W-1:0]  delta_c;
    logic signed [DELTA_W-1:0]  delta_d;
    logic signed [DELTA_W-1:0]  logit_background;
    logic signed [DELTA_W-1:0]  logit_object;
  } anchor_t;

  typedef struct packed {
    logic [BOX_W-1:0]   box_left;
    logic [BOX_W-1:0]   box_top;
    logic [BOX_W-1:0]   box_right;
    logic [BOX_W-1:0]   box_bottom;
    logic [SCORE_W-1:0] objectness;
  } box_t;

endpackage

>>> rtl/abdc_stream_if.sv
// ----------------------------------------------------------------------------
// abdc_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface abdc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/abdc_cfg_if.sv
// ----------------------------------------------------------------------------
// abdc_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface abdc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [abdc_pkg::CFG_INDEX_W-1:0]  index;
  logic [abdc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/abdc_exp.sv
// ----------------------------------------------------------------------------
// abdc_exp
// Five-stage fixed-point exp: log2(e) scaling, cubic 2^f, then shift.
// ----------------------------------------------------------------------------
module abdc_exp (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [abdc_pkg::EXP_IN_W-1:0]  x,
  output logic        [abdc_pkg::EXP_W-1:0]     y
);

  localparam int PROD_W = abdc_pkg::EXP_IN_W + 18;
  localparam logic signed [17:0] LOG2E_S = 18'(abdc_pkg::LOG2E_Q16);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] ysh;
  logic signed [7:0]        n_c, n2, n3, n4, nneg;
  logic        [15:0]       f2, f3;
  logic        [12:0]       t1;
  logic        [14:0]       t2;
  logic        [15:0]       t3;
  logic        [16:0]       p4;
  logic        [47:0]       wide;
  logic        [abdc_pkg::EXP_W-1:0] y_c;

  assign ysh  = prod >>> abdc_pkg::DELTA_FRAC_BITS;
  assign n_c  = 8'(ysh >>> 16);
  assign t3   = 16'((33'(f3) * (33'(abdc_pkg::POLY_C1) + 33'(t2))) >> 16);
  assign nneg = -n4;

  always_comb begin
    wide = 48'(p4) << n4[3:0];
    if (n4 >= 8'sd16) begin
      y_c = '1;
    end else if (n4 >= 8'sd0) begin
      y_c = (wide > 48'hFFFF_FFFF) ? '1 : abdc_pkg::EXP_W'(wide);
    end else if (n4 <= -8'sd32) begin
      y_c = '0;
    end else begin
      y_c = abdc_pkg::EXP_W'(p4 >> nneg[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(x) * PROD_W'(LOG2E_S);
      n2   <= n_c;
      f2   <= ysh[15:0];
      t1   <= 13'((29'(ysh[15:0]) * 29'(abdc_pkg::POLY_C3)) >> 16);
      n3   <= n2;
      f3   <= f2;
      t2   <= 15'((32'(f2) * (32'(abdc_pkg::POLY_C2) + 32'(t1))) >> 16);
      n4   <= n3;
      p4   <= 17'(1 << 16) + 17'(t3);
      y    <= y_c;
    end
  end

endmodule

>>> rtl/abdc_div.sv
// ----------------------------------------------------------------------------
// abdc_div
// Pipelined restoring divide for the objectness score:
// q = floor((2^32 + den/2) / den), den = 2^16 + e, a few quotient bits a stage.
// ----------------------------------------------------------------------------
module abdc_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [abdc_pkg::EXP_W-1:0]        e,
  output logic [abdc_pkg::QUOT_W-1:0]       q
);

  localparam int QW  = abdc_pkg::QUOT_W;
  localparam int BPS = 3;
  localparam int NST = (QW + BPS - 1) / BPS;
  localparam int DW  = abdc_pkg::EXP_W + 1;
  localparam int NW  = abdc_pkg::EXP_W + 2;

  logic [DW-1:0] den_c;
  logic [NW-1:0] num_c;

  logic [DW-1:0] den_q [NST];
  logic [DW-1:0] rem_q [NST];
  logic [QW-1:0] low_q [NST];
  logic [QW-1:0] quo_q [NST];

  assign den_c = DW'(e) + DW'(1 << 16);
  assign num_c = (NW'(1) << abdc_pkg::EXP_W) + NW'(den_c >> 1);

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [DW-1:0] d_in, r_in, r_nx;
    logic [QW-1:0] l_in, q_in, l_nx, q_nx;
    logic [DW:0]   trial;

    if (k == 0) begin : g_first
      assign d_in = den_c;
      assign r_in = DW'(num_c >> QW);
      assign l_in = num_c[QW-1:0];
      assign q_in = '0;
    end else begin : g_next
      assign d_in = den_q[k-1];
      assign r_in = rem_q[k-1];
      assign l_in = low_q[k-1];
      assign q_in = quo_q[k-1];
    end

    always_comb begin
      r_nx  = r_in;
      l_nx  = l_in;
      q_nx  = q_in;
      trial = '0;
      for (int s = 0; s < BPS; s++) begin
        if (k * BPS + s < QW) begin
          trial = {r_nx, l_nx[QW-1]};
          l_nx  = {l_nx[QW-2:0], 1'b0};
          if (trial >= {1'b0, d_in}) begin
            r_nx = DW'(trial - {1'b0, d_in});
            q_nx = {q_nx[QW-2:0], 1'b1};
          end else begin
            r_nx = DW'(trial);
            q_nx = {q_nx[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k] <= d_in;
        rem_q[k] <= r_nx;
        low_q[k] <= l_nx;
        quo_q[k] <= q_nx;
      end
    end
  end

  assign q = quo_q[NST-1];

endmodule

>>> rtl/anchor_box_decode_clip.sv
// ----------------------------------------------------------------------------
// anchor_box_decode_clip
// Per-anchor box decode, clip to the image and sigmoid objectness.
// ----------------------------------------------------------------------------
// Usage:
//   anchors : one anchor per transfer (corners, cell, deltas, two logits).
//   boxes   : one result per anchor, in order (clipped corners, objectness).
//   cfg     : register writes, index 0..3 (width, height, stride, mode);
//             always ready, other indexes are dropped. Write only while idle.
// Throughput: one anchor per clock unless the output stalls. Between the input
//   transfer and boxes.valid lie 13 pipeline levels, the first loaded at the
//   transfer edge, plus the output register;
//   the length is set by the exp unit (5 levels) and the objectness divider
//   (6 levels of up to 3 quotient bits) in series.
// Reset: clears all valid bits, the output and skid ones included, and loads the
//   register reset values (1024, 1024, 16, centre/log-scale mode).
// Stall: a skid register behind the output register keeps the pipeline
//   moving for one more transfer; when it fills, anchors.ready drops and
//   the whole pipeline holds until boxes.ready returns.
// ----------------------------------------------------------------------------
module anchor_box_decode_clip (
  input  logic          clk,
  input  logic          rst,
  abdc_stream_if.sink   anchors,
  abdc_stream_if.source boxes,
  abdc_cfg_if.sink      cfg
);

  localparam int CF    = abdc_pkg::COORD_FRAC_BITS;
  localparam int DF    = abdc_pkg::DELTA_FRAC_BITS;
  localparam int DLW   = abdc_pkg::DELTA_W;
  localparam int BW    = abdc_pkg::BOX_W;
  localparam int NLEV  = abdc_pkg::PIPE_LEVELS;
  localparam int SXW   = abdc_pkg::CELL_W + abdc_pkg::STRIDE_W;
  localparam int CW    = SXW + CF + 2;
  localparam int SW    = CW + 1;
  localparam int WW    = abdc_pkg::ANCHOR_W + 2;
  localparam int MW    = CW + 1;
  localparam int PW    = DLW + WW;
  localparam int XW    = PW + (17 - DF) + 3;
  localparam int HW    = abdc_pkg::EXP_W + 1 + WW + 1;
  localparam int VW    = HW + 2;
  localparam int OW    = VW - 17;
  localparam int RS    = DF - CF;
  localparam int RHALF = (RS > 0) ? (1 << (RS - 1)) : 0;
  localparam int DX    = DLW + 1;

  typedef struct packed {
    logic [BW-1:0] left;
    logic [BW-1:0] top;
    logic [BW-1:0] right;
    logic [BW-1:0] bottom;
  } corners_t;

  // configuration
  logic [abdc_pkg::SIZE_W-1:0]   image_width;
  logic [abdc_pkg::SIZE_W-1:0]   image_height;
  logic [abdc_pkg::STRIDE_W-1:0] cell_stride;
  logic                          transform_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= abdc_pkg::SIZE_W'(abdc_pkg::RST_IMAGE_WIDTH);
      image_height   <= abdc_pkg::SIZE_W'(abdc_pkg::RST_IMAGE_HEIGHT);
      cell_stride    <= abdc_pkg::STRIDE_W'(abdc_pkg::RST_CELL_STRIDE);
      transform_mode <= 1'(abdc_pkg::RST_MODE);
    end else if (cfg.valid) begin
      case (cfg.index)
        abdc_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg.data[abdc_pkg::SIZE_W-1:0];
        abdc_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg.data[abdc_pkg::SIZE_W-1:0];
        abdc_pkg::REG_CELL_STRIDE:    cell_stride    <= cfg.data[abdc_pkg::STRIDE_W-1:0];
        abdc_pkg::REG_TRANSFORM_MODE: transform_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [DX-1:0] round_delta(input logic signed [DLW-1:0] d);
    logic signed [DX-1:0] t;
    t = DX'(d) + DX'(RHALF);
    return t >>> RS;
  endfunction

  function automatic logic signed [OW-1:0] mid_to_coord(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] t;
    t = v + VW'(1 << 16);
    return OW'(t >>> 17);
  endfunction

  function automatic logic [BW-1:0] clip_corner(input logic signed [OW-1:0] x,
                                                input logic [abdc_pkg::SIZE_W-1:0] size);
    logic [abdc_pkg::SIZE_W-1:0] sz;
    logic signed [OW-1:0]        lo, hi, c;
    sz = size;
    if (sz == '0) sz = abdc_pkg::SIZE_W'(1);
    if (sz > abdc_pkg::SIZE_W'(abdc_pkg::SIZE_MAX)) sz = abdc_pkg::SIZE_W'(abdc_pkg::SIZE_MAX);
    lo = OW'(1 << CF);
    hi = OW'($signed({1'b0, sz})) <<< CF;
    c  = x;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    c = c - lo;
    return c[BW-1:0];
  endfunction

  // flow control: one enable for every level
  logic         en;
  logic [NLEV:1] v;
  logic         ov, sv;
  abdc_pkg::box_t od, sd, fin;

  assign en            = !sv;
  assign anchors.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NLEV-1:1], anchors.valid};
    end
  end

  // level 1
  abdc_pkg::anchor_t     a1;
  logic [SXW-1:0]        sx1, sy1;
  logic signed [DX-1:0]  bgob1;

  // level 2
  logic signed [CW-1:0]  l2, t2, r2, b2;
  logic signed [DLW-1:0] da2, db2, dc2, dd2;
  logic signed [CW-1:0]  shx, shy;

  // level 3..8
  logic signed [WW-1:0]  w3, h3, w4, h4, w5, h5, w6, h6;
  logic signed [SW-1:0]  lr3, tb3, lr4, tb4;
  logic signed [DLW-1:0] da3, db3;
  logic signed [MW-1:0]  ml3, mt3, mr3, mb3, ml4, mt4, mr4, mb4;
  logic signed [MW-1:0]  ml5, mt5, mr5, mb5, ml6, mt6, mr6, mb6;
  logic signed [MW-1:0]  ml7, mt7, mr7, mb7, ml8, mt8, mr8, mb8;
  logic signed [PW-1:0]  daw4, dbh4;
  logic signed [XW-1:0]  cx5, cy5, cx6, cy6, cx7, cy7;

  // level 7..12
  logic signed [HW-1:0]  hwp7, hhp7;
  logic signed [VW-1:0]  hwv, hhv;
  logic signed [OW-1:0]  cl8, ct8, cr8, cb8;
  corners_t              c9;
  corners_t              cd [3];

  logic [abdc_pkg::EXP_W-1:0]  exp_c, exp_d, exp_o;
  logic [abdc_pkg::QUOT_W-1:0] quot;

  assign shx = CW'($signed({1'b0, sx1})) <<< CF;
  assign shy = CW'($signed({1'b0, sy1})) <<< CF;
  assign hwv = VW'(hwp7) - VW'(1 << (16 + CF));
  assign hhv = VW'(hhp7) - VW'(1 << (16 + CF));

  abdc_exp u_exp_c (.clk(clk), .en(en), .x(abdc_pkg::EXP_IN_W'(a1.delta_c)), .y(exp_c));
  abdc_exp u_exp_d (.clk(clk), .en(en), .x(abdc_pkg::EXP_IN_W'(a1.delta_d)), .y(exp_d));
  abdc_exp u_exp_o (.clk(clk), .en(en), .x(abdc_pkg::EXP_IN_W'(bgob1)), .y(exp_o));

  abdc_div u_div (.clk(clk), .en(en), .e(exp_o), .q(quot));

  always_ff @(posedge clk) begin
    if (en) begin
      // level 1: capture, cell offsets, logit difference
      a1    <= anchors.payload;
      sx1   <= SXW'(anchors.payload.cell_col) * SXW'(cell_stride);
      sy1   <= SXW'(anchors.payload.cell_row) * SXW'(cell_stride);
      bgob1 <= DX'(anchors.payload.logit_background) - DX'(anchors.payload.logit_object);

      // level 2: shifted anchor
      l2  <= CW'(a1.anchor_left) + shx;
      t2  <= CW'(a1.anchor_top) + shy;
      r2  <= CW'(a1.anchor_right) + shx;
      b2  <= CW'(a1.anchor_bottom) + shy;
      da2 <= a1.delta_a;
      db2 <= a1.delta_b;
      dc2 <= a1.delta_c;
      dd2 <= a1.delta_d;

      // level 3: size, corner sums, additive corners
      w3  <= WW'(r2 - l2 + CW'(1 << CF));
      h3  <= WW'(b2 - t2 + CW'(1 << CF));
      lr3 <= SW'(l2) + SW'(r2);
      tb3 <= SW'(t2) + SW'(b2);
      ml3 <= MW'(l2) + MW'(round_delta(da2));
      mt3 <= MW'(t2) + MW'(round_delta(db2));
      mr3 <= MW'(r2) + MW'(round_delta(dc2));
      mb3 <= MW'(b2) + MW'(round_delta(dd2));
      da3 <= da2;
      db3 <= db2;

      // level 4: centre offsets
      daw4 <= PW'(da3) * PW'(w3);
      dbh4 <= PW'(db3) * PW'(h3);
      w4 <= w3;  h4 <= h3;  lr4 <= lr3;  tb4 <= tb3;
      ml4 <= ml3; mt4 <= mt3; mr4 <= mr3; mb4 <= mb3;

      // level 5: centres with 17 + CF fraction bits
      cx5 <= (XW'(lr4) <<< 16) + (XW'(daw4) <<< (17 - DF));
      cy5 <= (XW'(tb4) <<< 16) + (XW'(dbh4) <<< (17 - DF));
      w5 <= w4;  h5 <= h4;
      ml5 <= ml4; mt5 <= mt4; mr5 <= mr4; mb5 <= mb4;

      // level 6: wait for exp
      cx6 <= cx5; cy6 <= cy5; w6 <= w5; h6 <= h5;
      ml6 <= ml5; mt6 <= mt5; mr6 <= mr5; mb6 <= mb5;

      // level 7: scaled size
      hwp7 <= HW'($signed({1'b0, exp_c})) * HW'(w6);
      hhp7 <= HW'($signed({1'b0, exp_d})) * HW'(h6);
      cx7 <= cx6; cy7 <= cy6;
      ml7 <= ml6; mt7 <= mt6; mr7 <= mr6; mb7 <= mb6;

      // level 8: centre/scale corners back to coordinate format
      cl8 <= mid_to_coord(VW'(cx7) - hwv);
      cr8 <= mid_to_coord(VW'(cx7) + hwv);
      ct8 <= mid_to_coord(VW'(cy7) - hhv);
      cb8 <= mid_to_coord(VW'(cy7) + hhv);
      ml8 <= ml7; mt8 <= mt7; mr8 <= mr7; mb8 <= mb7;

      // level 9: mode select and clip
      if (transform_mode) begin
        c9.left   <= clip_corner(cl8, image_width);
        c9.top    <= clip_corner(ct8, image_height);
        c9.right  <= clip_corner(cr8, image_width);
        c9.bottom <= clip_corner(cb8, image_height);
      end else begin
        c9.left   <= clip_corner(OW'(ml8), image_width);
        c9.top    <= clip_corner(OW'(mt8), image_height);
        c9.right  <= clip_corner(OW'(mr8), image_width);
        c9.bottom <= clip_corner(OW'(mb8), image_height);
      end

      // levels 10..12: match the divider
      cd[0] <= c9;
      cd[1] <= cd[0];
      cd[2] <= cd[1];

      // level 13
      fin.box_left   <= cd[2].left;
      fin.box_top    <= cd[2].top;
      fin.box_right  <= cd[2].right;
      fin.box_bottom <= cd[2].bottom;
      fin.objectness <= (quot > abdc_pkg::QUOT_W'(16'hFFFF)) ? '1 : quot[15:0];
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (ov && !boxes.ready) begin
      if (v[NLEV] && en) sv <= 1'b1;
    end else if (sv) begin
      ov <= 1'b1;
      sv <= 1'b0;
    end else begin
      ov <= v[NLEV];
    end
  end

  always_ff @(posedge clk) begin
    if (ov && !boxes.ready) begin
      if (v[NLEV] && en) sd <= fin;
    end else if (sv) begin
      od <= sd;
    end else begin
      od <= fin;
    end
  end

  assign boxes.valid   = ov;
  assign boxes.payload = od;

endmodule

>>> rtl/abdc_checker.sv
// ----------------------------------------------------------------------------
// abdc_props
// Port-level checks of the anchor box decoder, bound to the top level.
// ----------------------------------------------------------------------------
module abdc_props (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input abdc_pkg::box_t out_payload
);

  localparam int MAX_INFLIGHT = abdc_pkg::PIPE_LEVELS + 2;

  logic [4:0] inflight;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 5'(in_xfer) - 5'(out_xfer);
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed or dropped");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> inflight != 5'd0)
    else $error("result transfer without a pending anchor");

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= 5'(MAX_INFLIGHT))
    else $error("more anchors in flight than the pipeline holds");

endmodule

bind anchor_box_decode_clip abdc_props u_abdc_props (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (anchors.valid),
  .in_ready    (anchors.ready),
  .out_valid   (boxes.valid),
  .out_ready   (boxes.ready),
  .out_payload (boxes.payload)
);
